// File: rtl/rmps_pkg.sv
// ----------------------------------------------------------------------------
// rmps_pkg - shared types and constants
// Defaults, register indexes, opcodes, FSM states and the control and chain
// structs used by the scheduler cells and the sequencer.
// ----------------------------------------------------------------------------
package rmps_pkg;

	localparam int MAX_TASKS_DEF        = 8;
	localparam int TICK_FIELD_WIDTH_DEF = 10;
	localparam int CFG_DATA_W           = 32;
	localparam int CFG_IDX_W            = 2;
	localparam int COUNT_W              = 4;
	localparam int TIME_W               = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TASK_COUNT,
		REG_PROMOTE_COUNT,
		REG_PROMOTE_TIME,
		REG_RESTORE_TIME
	} cfg_reg_t;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PROMOTE,
		ST_SELECT,
		ST_FINISH
	} state_t;

	// strobes broadcast to every cell
	typedef struct packed {
		logic load;
		logic rel;
		logic restore;
		logic probe_load;
		logic probe_shift;
		logic select;
	} cell_ctl_t;

	// strobes from the sequencer to the top-level datapath
	typedef struct packed {
		logic cmd_ready;
		logic tick_take;
		logic rsp_load;
	} top_ctl_t;

	// status seen by the sequencer
	typedef struct packed {
		logic cmd_valid;
		logic tick_op;
		logic halted;
		logic miss_any;
		logic promote_go;
		logic restore_hit;
		logic out_free;
	} seq_stat_t;

	// priority ripple, lowest index first
	typedef struct packed {
		logic miss_seen;
		logic rp_seen;
		logic r_seen;
	} chain_t;

endpackage

// File: rtl/rmps_ifs.sv
// ----------------------------------------------------------------------------
// rmps_ifs - command and result channels
// Valid/ready channels; a word moves on a clock edge with valid and ready high.
// ----------------------------------------------------------------------------
interface rmps_cmd_if import rmps_pkg::*; #(
	parameter int MAX_TASKS        = MAX_TASKS_DEF,
	parameter int TICK_FIELD_WIDTH = TICK_FIELD_WIDTH_DEF
);
	localparam int IDX_W = $clog2(MAX_TASKS);

	logic                        valid;
	logic                        ready;
	logic [0:0]                  operation;
	logic [IDX_W-1:0]            task_index;
	logic [TICK_FIELD_WIDTH-1:0] task_period;
	logic [TICK_FIELD_WIDTH-1:0] task_cost;

	modport source (output valid, operation, task_index, task_period, task_cost,
		input ready);
	modport sink (input valid, operation, task_index, task_period, task_cost,
		output ready);
endinterface

interface rmps_rsp_if import rmps_pkg::*; #(
	parameter int MAX_TASKS        = MAX_TASKS_DEF,
	parameter int TICK_FIELD_WIDTH = TICK_FIELD_WIDTH_DEF
);
	localparam int IDX_W = $clog2(MAX_TASKS);

	logic                             valid;
	logic                             ready;
	logic [TIME_W-1:0]                tick_time;
	logic                             idle;
	logic [IDX_W-1:0]                 running_task;
	logic [TIME_W-1:0]                job_number;
	logic [TIME_W-1:0]                job_deadline;
	logic signed [TICK_FIELD_WIDTH:0] work_left;
	logic                             promoted_run;
	logic                             deadline_miss;
	logic [IDX_W-1:0]                 missed_task;
	logic                             halted;

	modport source (output valid, tick_time, idle, running_task, job_number,
		job_deadline, work_left, promoted_run, deadline_miss, missed_task, halted,
		input ready);
	modport sink (input valid, tick_time, idle, running_task, job_number,
		job_deadline, work_left, promoted_run, deadline_miss, missed_task, halted,
		output ready);
endinterface

// File: rtl/rmps_cell.sv
// ----------------------------------------------------------------------------
// rmps_cell - one task slot
// Holds a task's period, cost, countdown, work and job count. Takes part in
// the priority ripple and passes its probe token around the period ring.
// ----------------------------------------------------------------------------
module rmps_cell import rmps_pkg::*; #(
	parameter int TICK_FIELD_WIDTH = TICK_FIELD_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cell_ctl_t                   ctl,
	input  logic                        load_hit,
	input  logic [TICK_FIELD_WIDTH-1:0] load_period,
	input  logic [TICK_FIELD_WIDTH-1:0] load_cost,
	input  logic                        active,
	input  logic                        in_range,
	input  logic                        time_nz,
	input  logic                        grant,
	input  chain_t                      chain_prev,
	output chain_t                      chain_next,
	input  logic [TICK_FIELD_WIDTH-1:0] probe_period_prev,
	input  logic                        probe_flag_prev,
	output logic [TICK_FIELD_WIDTH-1:0] probe_period,
	output logic                        probe_flag,
	output logic                        miss_first,
	output logic                        grant_p,
	output logic                        grant_r,
	output logic [TICK_FIELD_WIDTH-1:0] period,
	output logic [TICK_FIELD_WIDTH-1:0] rem,
	output logic [TIME_W-1:0]           jobs,
	output logic                        promoted
);

	localparam int TW = TICK_FIELD_WIDTH;

	logic [TW-1:0]     period_q, cost_q, cd_q, rem_q, probe_period_q, rem_dec;
	logic              ready_q, promoted_q, probe_flag_q, miss, rp, r;
	logic [TIME_W-1:0] jobs_q;

	assign rem_dec = (rem_q == '0) ? '0 : rem_q - TW'(1);

	always_ff @(posedge clk) begin
		if (ctl.load && load_hit) begin
			period_q <= load_period;
			cost_q   <= load_cost;
		end
		if (ctl.probe_load) begin
			probe_period_q <= period_q;
			probe_flag_q   <= in_range;
		end else if (ctl.probe_shift) begin
			probe_period_q <= probe_period_prev;
			probe_flag_q   <= probe_flag_prev;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cd_q       <= '0;
			rem_q      <= '0;
			ready_q    <= 1'b0;
			promoted_q <= 1'b0;
			jobs_q     <= '0;
		end else if (ctl.load && load_hit) begin
			cd_q       <= '0;
			rem_q      <= '0;
			ready_q    <= 1'b0;
			promoted_q <= 1'b0;
			jobs_q     <= '0;
		end else begin
			if (ctl.rel && active) begin
				if (cd_q == '0) begin
					ready_q <= 1'b1;
					rem_q   <= cost_q;
					cd_q    <= (period_q == '0) ? '0 : period_q - TW'(1);
				end else begin
					cd_q <= cd_q - TW'(1);
				end
			end
			// a visiting token from a promoted slot lifts every slot of equal period
			if (ctl.restore) begin
				promoted_q <= 1'b0;
			end else if (ctl.probe_shift && active && probe_flag_q
					&& probe_period_q == period_q) begin
				promoted_q <= 1'b1;
			end
			if (ctl.select && grant) begin
				rem_q <= rem_dec;
				if (rem_dec == '0) begin
					promoted_q <= 1'b0;
					jobs_q     <= jobs_q + TIME_W'(1);
					ready_q    <= 1'b0;
				end
			end
		end
	end

	always_comb begin
		miss = active && (cd_q == '0) && (rem_q != '0) && time_nz;
		rp   = active && ready_q && promoted_q;
		r    = active && ready_q;
		miss_first = miss && !chain_prev.miss_seen;
		grant_p    = rp && !chain_prev.rp_seen;
		grant_r    = r && !chain_prev.r_seen;
		chain_next.miss_seen = chain_prev.miss_seen || miss;
		chain_next.rp_seen   = chain_prev.rp_seen || rp;
		chain_next.r_seen    = chain_prev.r_seen || r;
	end

	assign probe_period = probe_period_q;
	assign probe_flag   = probe_flag_q;
	assign period       = period_q;
	assign rem          = rem_q;
	assign jobs         = jobs_q;
	assign promoted     = promoted_q;

endmodule

// File: rtl/rmps_ctrl.sv
// ----------------------------------------------------------------------------
// rmps_ctrl - tick sequencer
// Steps a tick through release, the promotion ring sweep, selection and the
// result write, and issues the strobes for cells and datapath.
// ----------------------------------------------------------------------------
module rmps_ctrl import rmps_pkg::*; #(
	parameter int MAX_TASKS = MAX_TASKS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  seq_stat_t stat,
	output cell_ctl_t ctl,
	output top_ctl_t  tctl
);

	localparam int SWEEP_W = $clog2(MAX_TASKS);
	localparam logic [SWEEP_W-1:0] SWEEP_LAST = SWEEP_W'(MAX_TASKS - 1);

	state_t             state_q, state_d;
	logic [SWEEP_W-1:0] sweep_q;
	logic               take, take_tick;

	assign take      = (state_q == ST_IDLE) && stat.cmd_valid;
	assign take_tick = take && stat.tick_op;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (take_tick) begin
					if (stat.halted || stat.miss_any)
						state_d = ST_FINISH;
					else if (stat.promote_go)
						state_d = ST_PROMOTE;
					else
						state_d = ST_SELECT;
				end
			end
			ST_PROMOTE: begin
				if (sweep_q == SWEEP_LAST)
					state_d = ST_SELECT;
			end
			ST_SELECT: state_d = ST_FINISH;
			ST_FINISH: begin
				if (stat.out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl.load        = take && !stat.tick_op;
		ctl.rel         = take_tick && !stat.halted;
		ctl.restore     = take_tick && !stat.halted && stat.restore_hit;
		ctl.probe_load  = take_tick && !stat.halted;
		ctl.probe_shift = (state_q == ST_PROMOTE);
		ctl.select      = (state_q == ST_SELECT);
		tctl.cmd_ready  = (state_q == ST_IDLE);
		tctl.tick_take  = take_tick;
		tctl.rsp_load   = (state_q == ST_FINISH) && stat.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sweep_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_PROMOTE)
				sweep_q <= (sweep_q == SWEEP_LAST) ? '0 : sweep_q + SWEEP_W'(1);
		end
	end

endmodule

// File: rtl/rate_monotonic_promotion_scheduler.sv
// ----------------------------------------------------------------------------
// rate_monotonic_promotion_scheduler - RM scheduler with priority promotion
// Row of task cells with a priority ripple and a period ring for promotion.
//
//   channel   dir   handshake       word
//   cmd       in    valid/ready     load task slot or advance one tick
//   rsp       out   valid/ready     one result word per tick
//   cfg_*     in    write enable    task_count, promote_count, promote/restore
//
// A load is written as it is taken. A tick runs release in the cycle it is
// taken, priority select across the cell row, then the deadline multiply into
// the result register. A tick at the promote time first sweeps the period
// ring. Halted and missing ticks go straight to the result write.
// Reset clears all control state; no clearing pass. A stalled result holds
// the sequencer in its last step; loads wait until then.
// ----------------------------------------------------------------------------
module rate_monotonic_promotion_scheduler import rmps_pkg::*; #(
	parameter int MAX_TASKS        = MAX_TASKS_DEF,
	parameter int TICK_FIELD_WIDTH = TICK_FIELD_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	rmps_cmd_if.sink              cmd,
	rmps_rsp_if.source            rsp,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int TW    = TICK_FIELD_WIDTH;
	localparam int IDX_W = $clog2(MAX_TASKS);
	localparam int N_W   = $clog2(MAX_TASKS + 1);

	logic [COUNT_W-1:0] task_count_q, promote_count_q;
	logic [TIME_W-1:0]  promote_time_q, restore_time_q, time_q;
	logic               halted_q, kind_halt_q, kind_miss_q, rsp_valid_q;
	logic [IDX_W-1:0]   missed_q;

	logic [N_W-1:0] n_act, pc_act, lo_act;

	cell_ctl_t ctl;
	top_ctl_t  tctl;
	seq_stat_t stat;

	chain_t          chain [MAX_TASKS+1];
	logic [TW-1:0]   c_probe_period [MAX_TASKS];
	logic            c_probe_flag   [MAX_TASKS];
	logic [TW-1:0]   c_period [MAX_TASKS];
	logic [TW-1:0]   c_rem    [MAX_TASKS];
	logic [TIME_W-1:0] c_jobs [MAX_TASKS];
	logic [MAX_TASKS-1:0] c_promoted, c_miss_first, c_grant_p, c_grant_r, grant;
	logic [MAX_TASKS-1:0] active, in_range, load_hit;

	logic [IDX_W-1:0]  miss_idx, sel_idx;
	logic [TW-1:0]     sel_period, sel_rem;
	logic [TIME_W-1:0] sel_jobs;
	logic              sel_promoted;

	// select stage
	logic              sel_valid_s1, sel_promoted_s1;
	logic [IDX_W-1:0]  sel_idx_s1;
	logic [TW-1:0]     sel_period_s1;
	logic [TIME_W-1:0] job_s1;
	logic [TW:0]       work_left_s1;

	logic [TW+TIME_W-1:0] deadline_prod;
	logic                 out_free;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			task_count_q    <= COUNT_W'(1);
			promote_count_q <= '0;
			promote_time_q  <= '0;
			restore_time_q  <= '0;
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				REG_TASK_COUNT:    task_count_q    <= cfg_data[COUNT_W-1:0];
				REG_PROMOTE_COUNT: promote_count_q <= cfg_data[COUNT_W-1:0];
				REG_PROMOTE_TIME:  promote_time_q  <= cfg_data[TIME_W-1:0];
				REG_RESTORE_TIME:  restore_time_q  <= cfg_data[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	// tasks in use and the promoted tail of the list
	always_comb begin
		n_act  = (int'(task_count_q) > MAX_TASKS) ? N_W'(MAX_TASKS) : N_W'(task_count_q);
		pc_act = (int'(promote_count_q) > int'(n_act)) ? n_act : N_W'(promote_count_q);
		lo_act = n_act - pc_act;
	end

	assign out_free = !rsp_valid_q || rsp.ready;

	always_comb begin
		stat.cmd_valid   = cmd.valid;
		stat.tick_op     = (op_t'(cmd.operation) == OP_TICK);
		stat.halted      = halted_q;
		stat.miss_any    = chain[MAX_TASKS].miss_seen;
		stat.restore_hit = (time_q == restore_time_q);
		stat.promote_go  = (time_q == promote_time_q) && (time_q != restore_time_q)
			&& (pc_act != '0);
		stat.out_free    = out_free;
	end

	rmps_ctrl #(.MAX_TASKS(MAX_TASKS)) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctl    (ctl),
		.tctl   (tctl)
	);

	assign cmd.ready = tctl.cmd_ready;
	assign chain[0]  = '0;

	for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
		localparam int PREV = (i == 0) ? MAX_TASKS - 1 : i - 1;

		assign active[i]   = (i < int'(task_count_q));
		assign in_range[i] = active[i] && (i >= int'(lo_act));
		assign load_hit[i] = (cmd.task_index == IDX_W'(i));

		rmps_cell #(.TICK_FIELD_WIDTH(TW)) u_cell (
			.clk               (clk),
			.arst_n            (arst_n),
			.ctl               (ctl),
			.load_hit          (load_hit[i]),
			.load_period       (cmd.task_period),
			.load_cost         (cmd.task_cost),
			.active            (active[i]),
			.in_range          (in_range[i]),
			.time_nz           (time_q != '0),
			.grant             (grant[i]),
			.chain_prev        (chain[i]),
			.chain_next        (chain[i+1]),
			.probe_period_prev (c_probe_period[PREV]),
			.probe_flag_prev   (c_probe_flag[PREV]),
			.probe_period      (c_probe_period[i]),
			.probe_flag        (c_probe_flag[i]),
			.miss_first        (c_miss_first[i]),
			.grant_p           (c_grant_p[i]),
			.grant_r           (c_grant_r[i]),
			.period            (c_period[i]),
			.rem               (c_rem[i]),
			.jobs              (c_jobs[i]),
			.promoted          (c_promoted[i])
		);
	end

	// grants are one-hot, so the row collapses with and-or
	always_comb begin
		grant        = chain[MAX_TASKS].rp_seen ? c_grant_p : c_grant_r;
		miss_idx     = '0;
		sel_idx      = '0;
		sel_period   = '0;
		sel_rem      = '0;
		sel_jobs     = '0;
		sel_promoted = 1'b0;
		for (int i = 0; i < MAX_TASKS; i++) begin
			if (c_miss_first[i])
				miss_idx = miss_idx | IDX_W'(i);
			if (grant[i]) begin
				sel_idx      = sel_idx | IDX_W'(i);
				sel_period   = sel_period | c_period[i];
				sel_rem      = sel_rem | c_rem[i];
				sel_jobs     = sel_jobs | c_jobs[i];
				sel_promoted = sel_promoted | c_promoted[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.select) begin
			sel_valid_s1    <= chain[MAX_TASKS].r_seen;
			sel_idx_s1      <= sel_idx;
			sel_period_s1   <= sel_period;
			job_s1          <= sel_jobs + TIME_W'(1);
			work_left_s1    <= {1'b0, sel_rem} - (TW+1)'(1);
			sel_promoted_s1 <= sel_promoted;
		end
		if (tctl.tick_take)
			missed_q <= miss_idx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			halted_q    <= 1'b0;
			kind_halt_q <= 1'b0;
			kind_miss_q <= 1'b0;
			time_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (tctl.tick_take) begin
				kind_halt_q <= halted_q;
				kind_miss_q <= !halted_q && chain[MAX_TASKS].miss_seen;
			end
			if (ctl.rel && chain[MAX_TASKS].miss_seen)
				halted_q <= 1'b1;
			if (tctl.rsp_load && !kind_halt_q && !kind_miss_q)
				time_q <= time_q + TIME_W'(1);
			if (tctl.rsp_load)
				rsp_valid_q <= 1'b1;
			else if (rsp.ready)
				rsp_valid_q <= 1'b0;
		end
	end

	assign deadline_prod = {{TIME_W{1'b0}}, sel_period_s1} * {{TW{1'b0}}, job_s1};

	// result word
	always_ff @(posedge clk) begin
		if (tctl.rsp_load) begin
			rsp.tick_time <= time_q;
			if (kind_halt_q || kind_miss_q) begin
				rsp.idle          <= 1'b1;
				rsp.running_task  <= '0;
				rsp.job_number    <= '0;
				rsp.job_deadline  <= '0;
				rsp.work_left     <= '0;
				rsp.promoted_run  <= 1'b0;
				rsp.deadline_miss <= kind_miss_q;
				rsp.missed_task   <= kind_miss_q ? missed_q : '0;
				rsp.halted        <= 1'b1;
			end else begin
				rsp.idle          <= !sel_valid_s1;
				rsp.running_task  <= sel_valid_s1 ? sel_idx_s1 : '0;
				rsp.job_number    <= sel_valid_s1 ? job_s1 : '0;
				rsp.job_deadline  <= sel_valid_s1 ? deadline_prod[TIME_W-1:0] : '0;
				rsp.work_left     <= sel_valid_s1 ? $signed(work_left_s1) : '0;
				rsp.promoted_run  <= sel_valid_s1 && sel_promoted_s1;
				rsp.deadline_miss <= 1'b0;
				rsp.missed_task   <= '0;
				rsp.halted        <= 1'b0;
			end
		end
	end

	assign rsp.valid = rsp_valid_q;

endmodule

// File: rtl/rmps_checker.sv
// ----------------------------------------------------------------------------
// rmps_checker - port-level checks for the scheduler
// Watches the result channel: stall hold, miss and idle word shape, and the
// frozen state after a halt.
// ----------------------------------------------------------------------------
module rmps_checker import rmps_pkg::*; #(
	parameter int MAX_TASKS        = MAX_TASKS_DEF,
	parameter int TICK_FIELD_WIDTH = TICK_FIELD_WIDTH_DEF
) (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  rsp_valid,
	input logic                                  rsp_ready,
	input logic [TIME_W-1:0]                     rsp_tick_time,
	input logic                                  rsp_idle,
	input logic [$clog2(MAX_TASKS)-1:0]          rsp_running_task,
	input logic [TIME_W-1:0]                     rsp_job_number,
	input logic [TIME_W-1:0]                     rsp_job_deadline,
	input logic signed [TICK_FIELD_WIDTH:0]      rsp_work_left,
	input logic                                  rsp_promoted_run,
	input logic                                  rsp_deadline_miss,
	input logic [$clog2(MAX_TASKS)-1:0]          rsp_missed_task,
	input logic                                  rsp_halted
);

	logic              halt_seen_q;
	logic [TIME_W-1:0] halt_time_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			halt_seen_q <= 1'b0;
		else if (rsp_valid && rsp_ready && rsp_halted)
			halt_seen_q <= 1'b1;
	end

	always_ff @(posedge clk) begin
		if (rsp_valid && rsp_ready && rsp_halted)
			halt_time_q <= rsp_tick_time;
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable({rsp_tick_time, rsp_idle,
			rsp_running_task, rsp_job_number, rsp_job_deadline, rsp_work_left,
			rsp_promoted_run, rsp_deadline_miss, rsp_missed_task, rsp_halted}))
		else $error("result word changed while stalled");

	a_miss_shape: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_deadline_miss |-> rsp_halted && rsp_idle)
		else $error("deadline miss without halt and idle");

	a_idle_shape: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_idle |-> rsp_running_task == '0 && rsp_job_number == '0
			&& rsp_job_deadline == '0 && rsp_work_left == '0 && !rsp_promoted_run)
		else $error("idle word carries run fields");

	a_halt_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && halt_seen_q |-> rsp_halted && rsp_tick_time == halt_time_q)
		else $error("scheduler moved after halt");

endmodule

bind rate_monotonic_promotion_scheduler rmps_checker #(
	.MAX_TASKS        (MAX_TASKS),
	.TICK_FIELD_WIDTH (TICK_FIELD_WIDTH)
) u_rmps_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_tick_time     (rsp.tick_time),
	.rsp_idle          (rsp.idle),
	.rsp_running_task  (rsp.running_task),
	.rsp_job_number    (rsp.job_number),
	.rsp_job_deadline  (rsp.job_deadline),
	.rsp_work_left     (rsp.work_left),
	.rsp_promoted_run  (rsp.promoted_run),
	.rsp_deadline_miss (rsp.deadline_miss),
	.rsp_missed_task   (rsp.missed_task),
	.rsp_halted        (rsp.halted)
);

// File: sim/rate_monotonic_promotion_scheduler_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rate_monotonic_promotion_scheduler_tb - self-checking bench for the scheduler
// Drives load and tick words on the command channel and keeps a cycle-free
// model of the task row: releases, promotion window, priority pick and the
// deadline miss halt. Every result word is compared field by field with the
// oldest predicted tick. Stimulus keeps the task set schedulable by reloading
// a task about to miss, so the halt is only reached in the last test.
// ----------------------------------------------------------------------------
module rate_monotonic_promotion_scheduler_tb;
	import rmps_pkg::*;

	localparam int TASKS         = MAX_TASKS_DEF;
	localparam int SETTLE_CYCLES = 16;

	typedef struct packed {
		logic [31:0] tick_time;
		logic        idle;
		logic [2:0]  running_task;
		logic [31:0] job_number;
		logic [31:0] job_deadline;
		logic [10:0] work_left;
		logic        promoted_run;
		logic        deadline_miss;
		logic [2:0]  missed_task;
		logic        halted;
	} tick_word_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_write;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	rmps_cmd_if cmd_if ();
	rmps_rsp_if rsp_if ();

	rate_monotonic_promotion_scheduler u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_if),
		.rsp       (rsp_if),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	// scheduler model state
	logic [3:0]  reg_task_count   = 4'd1;
	logic [3:0]  reg_boost_count  = 4'd0;
	logic [31:0] reg_boost_time   = '0;
	logic [31:0] reg_restore_time = '0;
	logic [9:0]  slot_period    [TASKS] = '{default: '0};
	logic [9:0]  slot_cost      [TASKS] = '{default: '0};
	logic [9:0]  slot_countdown [TASKS] = '{default: '0};
	logic [9:0]  slot_work      [TASKS] = '{default: '0};
	logic [31:0] slot_jobs      [TASKS] = '{default: '0};
	logic [TASKS-1:0] slot_ready = '0;
	logic [TASKS-1:0] slot_boost = '0;
	logic [31:0] sched_now    = '0;
	logic        sched_halted = 1'b0;

	tick_word_t expected_ticks [$];
	int errors        = 0;
	int send_gap_pct  = 16;
	int rsp_stall_pct = 77;
	int hold_request  = 0;
	int hold_left     = 0;

	function automatic tick_word_t compute_tick_result();
		tick_word_t r;
		int n, pc, sel, i, j;
		r = '0;
		r.tick_time = sched_now;
		if (sched_halted) begin
			r.idle = 1'b1;
			r.halted = 1'b1;
			return r;
		end
		n = (int'(reg_task_count) > TASKS) ? TASKS : int'(reg_task_count);
		for (i = 0; i < n; i++) begin
			if (slot_countdown[i] == 0) begin
				slot_ready[i] = 1'b1;
				if (slot_work[i] != 0 && sched_now != 0) begin
					// later slots are left untouched, time stays put
					sched_halted = 1'b1;
					r.idle = 1'b1;
					r.deadline_miss = 1'b1;
					r.missed_task = 3'(i);
					r.halted = 1'b1;
					return r;
				end
				slot_work[i] = slot_cost[i];
				slot_countdown[i] = (slot_period[i] != 0) ? slot_period[i] - 10'd1 : 10'd0;
			end else begin
				slot_countdown[i] = slot_countdown[i] - 10'd1;
			end
		end
		if (sched_now == reg_boost_time) begin
			pc = (int'(reg_boost_count) > n) ? n : int'(reg_boost_count);
			for (i = n - pc; i < n; i++) begin
				slot_boost[i] = 1'b1;
				for (j = 0; j < n; j++)
					if (slot_period[j] == slot_period[i])
						slot_boost[j] = 1'b1;
			end
		end
		if (sched_now == reg_restore_time)
			slot_boost = '0;
		sel = -1;
		for (i = 0; i < n && sel < 0; i++)
			if (slot_ready[i] && slot_boost[i])
				sel = i;
		for (i = 0; i < n && sel < 0; i++)
			if (slot_ready[i])
				sel = i;
		if (sel < 0) begin
			r.idle = 1'b1;
		end else begin
			r.running_task = 3'(sel);
			r.job_number = slot_jobs[sel] + 32'd1;
			r.job_deadline = 32'(slot_period[sel]) * r.job_number;
			r.work_left = 11'(slot_work[sel]) - 11'd1;
			r.promoted_run = slot_boost[sel];
			if (slot_work[sel] != 0)
				slot_work[sel] = slot_work[sel] - 10'd1;
			if (slot_work[sel] == 0) begin
				slot_boost[sel] = 1'b0;
				slot_jobs[sel] = r.job_number;
				slot_ready[sel] = 1'b0;
			end
		end
		sched_now = sched_now + 32'd1;
		return r;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			errors++;
		end
	endfunction

	// result word checker
	always @(posedge clk) begin
		tick_word_t want;
		if (rsp_if.valid && rsp_if.ready) begin
			if (expected_ticks.size() == 0) begin
				$error("result word with nothing pending, tick_time 0x%0h", rsp_if.tick_time);
				errors++;
			end else begin
				want = expected_ticks.pop_front();
				check_field("tick_time", want.tick_time, rsp_if.tick_time);
				check_field("idle", want.idle, rsp_if.idle);
				check_field("running_task", want.running_task, rsp_if.running_task);
				check_field("job_number", want.job_number, rsp_if.job_number);
				check_field("job_deadline", want.job_deadline, rsp_if.job_deadline);
				// compare the raw 11-bit pattern, no sign extension
				check_field("work_left", want.work_left, $unsigned(rsp_if.work_left));
				check_field("promoted_run", want.promoted_run, rsp_if.promoted_run);
				check_field("deadline_miss", want.deadline_miss, rsp_if.deadline_miss);
				check_field("missed_task", want.missed_task, rsp_if.missed_task);
				check_field("halted", want.halted, rsp_if.halted);
			end
		end
	end

	// result sink: random stalls plus an occasional long hold-off
	initial rsp_if.ready = 1'b0;
	always @(posedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			rsp_if.ready <= 1'b0;
		end else begin
			rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
		end
	end

	// valid is only dropped on a gap, so back-to-back words keep it high
	task automatic send_word(op_t op, logic [2:0] idx, logic [9:0] period, logic [9:0] cost);
		while ($urandom_range(99) < send_gap_pct) begin
			cmd_if.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_if.valid <= 1'b1;
		cmd_if.operation <= op;
		cmd_if.task_index <= idx;
		cmd_if.task_period <= period;
		cmd_if.task_cost <= cost;
		do @(posedge clk); while (!cmd_if.ready);
		if (op == OP_LOAD) begin
			slot_period[idx] = period;
			slot_cost[idx] = cost;
			slot_countdown[idx] = '0;
			slot_work[idx] = '0;
			slot_ready[idx] = 1'b0;
			slot_boost[idx] = 1'b0;
			slot_jobs[idx] = '0;
		end else begin
			expected_ticks.push_back(compute_tick_result());
		end
	endtask

	// tick, first reloading any slot that would miss on it
	task automatic send_tick();
		int late, n, i;
		forever begin
			late = -1;
			n = (int'(reg_task_count) > TASKS) ? TASKS : int'(reg_task_count);
			if (!sched_halted)
				for (i = n - 1; i >= 0; i--)
					if (slot_countdown[i] == 0 && slot_work[i] != 0 && sched_now != 0)
						late = i;
			if (late < 0)
				break;
			send_word(OP_LOAD, 3'(late), slot_period[late], slot_cost[late] >> 1);
		end
		send_word(OP_TICK, 3'($urandom), 10'($urandom), 10'($urandom));
	endtask

	task automatic wait_drained();
		cmd_if.valid <= 1'b0;
		while (expected_ticks.size() != 0)
			@(posedge clk);
		// a load or a promote sweep may still be in flight
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_TASK_COUNT:    reg_task_count = val[3:0];
			REG_PROMOTE_COUNT: reg_boost_count = val[3:0];
			REG_PROMOTE_TIME:  reg_boost_time = val;
			REG_RESTORE_TIME:  reg_restore_time = val;
			default: ;
		endcase
	endtask

	task automatic program_regs(logic [3:0] tcount, logic [3:0] pcount, logic [31:0] ptime,
		logic [31:0] rtime);
		wait_drained();
		// junk in the upper bits of the count registers
		write_reg(REG_TASK_COUNT, {28'($urandom), tcount});
		write_reg(REG_PROMOTE_COUNT, {28'($urandom), pcount});
		write_reg(REG_PROMOTE_TIME, ptime);
		write_reg(REG_RESTORE_TIME, rtime);
		cfg_write <= 1'b0;
	endtask

	task automatic test_task_loads();
		int s;
		// slot 0: period zero acts as one, zero-cost jobs
		send_word(OP_LOAD, 3'd0, 10'd0, 10'd0);
		for (s = 1; s < TASKS - 1; s++)
			send_word(OP_LOAD, 3'(s), 10'(4 * s), 10'(s % 2));
		send_word(OP_LOAD, 3'd7, 10'd1023, 10'd1023);
		repeat (3) send_tick();
	endtask

	task automatic test_count_extremes();
		program_regs(4'd0, 4'd0, '1, '1);
		repeat (2) send_tick();
		// clamped counts, promotion right away and never undone
		program_regs(4'd15, 4'd15, sched_now, '1);
		repeat (4) send_tick();
		// promote and restore on one tick
		program_regs(4'd8, 4'd8, sched_now + 32'd1, sched_now + 32'd1);
		repeat (3) send_tick();
	endtask

	task automatic test_random_phase(int n_items);
		logic [9:0]  per;
		logic [31:0] ptime, rtime;
		int tc, pc, s, k;
		tc = $urandom_range(1, TASKS);
		pc = $urandom_range(0, tc + 1);
		ptime = sched_now + $urandom_range(0, 40);
		case ($urandom_range(3))
			0: rtime = ptime;
			1: rtime = ptime + $urandom_range(1, 80);
			2: rtime = ptime - $urandom_range(1, 30);
			default: rtime = '1;
		endcase
		program_regs(4'(tc), 4'(pc), ptime, rtime);
		// sorted periods, step of zero gives shared periods
		per = 10'($urandom_range(1, 6));
		for (s = 0; s < TASKS; s++) begin
			send_word(OP_LOAD, 3'(s), per, 10'($urandom_range(0, per / 4)));
			per = per + 10'($urandom_range(0, 5));
		end
		for (k = 0; k < n_items; k++) begin
			if ($urandom_range(99) < 8) begin
				if ($urandom_range(1))
					send_word(OP_LOAD, 3'($urandom), 10'($urandom_range(1, 1023)),
						10'($urandom));
				else
					send_word(OP_LOAD, 3'($urandom), 10'($urandom_range(1, 40)),
						10'($urandom_range(0, 4)));
			end else begin
				send_tick();
			end
		end
	endtask

	task automatic test_backpressure();
		hold_request = 300;
		repeat (40) send_tick();
		wait_drained();
	endtask

	task automatic test_deadline_miss();
		program_regs(4'd2, 4'd0, '1, '1);
		// slot 0 needs two units every tick: misses on its second release
		send_word(OP_LOAD, 3'd0, 10'd1, 10'd2);
		send_word(OP_LOAD, 3'd1, 10'd5, 10'd1);
		repeat (2) send_word(OP_TICK, 3'($urandom), 10'($urandom), 10'($urandom));
		repeat (2) send_word(OP_TICK, 3'($urandom), 10'($urandom), 10'($urandom));
		// loads still go in while halted
		send_word(OP_LOAD, 3'd1, 10'd3, 10'd0);
		send_word(OP_TICK, 3'($urandom), 10'($urandom), 10'($urandom));
	endtask

	initial begin
		int ph;
		arst_n = 1'b0;
		cmd_if.valid = 1'b0;
		cmd_if.operation = OP_LOAD;
		cmd_if.task_index = '0;
		cmd_if.task_period = '0;
		cmd_if.task_cost = '0;
		cfg_write = 1'b0;
		cfg_index = REG_TASK_COUNT;
		cfg_data = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		test_task_loads();
		test_count_extremes();
		for (ph = 0; ph < 10; ph++) begin
			if (ph == 4) begin
				send_gap_pct = 77;
				rsp_stall_pct = 16;
			end else if (ph == 7) begin
				send_gap_pct = 0;
				rsp_stall_pct = 0;
			end
			test_random_phase(115);
		end
		test_backpressure();
		test_deadline_miss();
		wait_drained();
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#8_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
